FILE: hw/rtl/ungapped_hamming_read_aligner_top_assert.svh
// Assertion macros for the read aligner checker.
`ifndef UNGAPPED_HAMMING_READ_ALIGNER_TOP_ASSERT_SVH
`define UNGAPPED_HAMMING_READ_ALIGNER_TOP_ASSERT_SVH
// Implication checked every clock outside reset.
`define UHRA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define UHRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: hw/rtl/uhra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package uhra_pkg;
   localparam int RefDepth   = 16384;
   localparam int MaxContigs = 16;
   localparam int MaxRead    = 256;
   localparam int RefAw      = $clog2(RefDepth);
   localparam int ContigAw   = $clog2(MaxContigs);
   localparam int ReadAw     = $clog2(MaxRead);
   localparam int RefCw      = RefAw + 1;
   localparam int ReadCw     = ReadAw + 1;
   localparam int CtCw       = ContigAw + 1;
   localparam logic [3:0] LimitCap = 4'd12;

   localparam logic [1:0] ReqRef   = 2'd0;
   localparam logic [1:0] ReqRead  = 2'd1;
   localparam logic [1:0] ReqClear = 2'd2;

   localparam logic [1:0] StatOk       = 2'd0;
   localparam logic [1:0] StatEmpty    = 2'd1;
   localparam logic [1:0] StatReadOvf  = 2'd2;
   localparam logic [1:0] StatRefOvf   = 2'd3;

   localparam logic [2:0] CodeOther = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CONTIG, ST_WINDOW, ST_BASE, ST_DRAIN, ST_NEXT, ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;       // begin search: clear best, reset contig scan
      logic load_contig; // fetch contig bounds
      logic win_start;   // reset base counter for a window
      logic base_step;   // issue one base compare
      logic win_close;   // fold window score into best
      logic win_adv;     // next strand / position
      logic contig_adv;  // move to next contig
      logic finish;      // search over: drop the buffered read
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic bad_status;  // no search needed
      logic contigs_done;
      logic contig_fits;
      logic last_base;   // issuing final base of window
      logic windows_done;
   } stat_type;

   function automatic logic [2:0] encode_base(input logic [7:0] ch);
      logic [7:0] c;
      c = ch;
      if (ch >= 8'h61 && ch <= 8'h7a) c = ch - 8'h20;
      case (c)
         8'h41:   encode_base = 3'd0;
         8'h43:   encode_base = 3'd1;
         8'h47:   encode_base = 3'd2;
         8'h54:   encode_base = 3'd3;
         default: encode_base = CodeOther;
      endcase
   endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/uhra_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module uhra_ctrl import uhra_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     go,
   input  wire stat_type stat,
   output ctrl_type      ctrl,
   output logic          busy,
   output logic          done
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      busy     = (state_ff != ST_IDLE);
      done     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               ctrl.start = 1'b1;
               state_in   = ST_CONTIG;
            end
         end
         ST_CONTIG: begin
            if (stat.bad_status || stat.contigs_done) state_in = ST_DONE;
            else begin
               ctrl.load_contig = 1'b1;
               state_in = ST_WINDOW;
            end
         end
         ST_WINDOW: begin
            if (!stat.contig_fits || stat.windows_done) begin
               ctrl.contig_adv = 1'b1;
               state_in = ST_CONTIG;
            end else begin
               ctrl.win_start = 1'b1;
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            ctrl.base_step = 1'b1;
            if (stat.last_base) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_NEXT;
         ST_NEXT: begin
            ctrl.win_close = 1'b1;
            ctrl.win_adv   = 1'b1;
            state_in = ST_WINDOW;
         end
         ST_DONE: begin
            done = 1'b1;
            ctrl.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

FILE: hw/rtl/uhra_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module uhra_datapath import uhra_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_take,
   input  wire logic [1:0]  in_type,
   input  wire logic [7:0]  in_char,
   input  wire logic        in_last,
   input  wire logic [3:0]  limit_raw,
   input  wire ctrl_type    ctrl,
   output stat_type         stat,
   output logic             res_mapped,
   output logic [3:0]       res_contig,
   output logic [13:0]      res_pos,
   output logic             res_rev,
   output logic [3:0]       res_miss,
   output logic [15:0]      res_ties,
   output logic [1:0]       res_status
);
   logic [2:0]       ref_mem [RefDepth];
   logic [2:0]       read_mem [MaxRead];
   logic [RefCw-1:0] end_mem [MaxContigs];

   logic [CtCw-1:0]   ctot_ff;
   logic [RefCw-1:0]  rfill_ff;
   logic [ReadCw-1:0] qfill_ff;
   logic              rovf_ff, qovf_ff;

   logic [2:0] code;
   assign code = encode_base(in_char);

   logic is_ref, is_read, ref_full_tab;
   assign is_ref  = in_take && in_type == ReqRef;
   assign is_read = in_take && in_type == ReqRead;
   assign ref_full_tab = ctot_ff >= CtCw'(MaxContigs);

   always_ff @(posedge clock) begin
      if (is_ref && !ref_full_tab && rfill_ff < RefCw'(RefDepth))
         ref_mem[rfill_ff[RefAw-1:0]] <= code;
      if (is_read && qfill_ff < ReadCw'(MaxRead))
         read_mem[qfill_ff[ReadAw-1:0]] <= code;
   end

   logic [RefCw-1:0] rfill_next;
   always_comb begin
      rfill_next = rfill_ff;
      if (rfill_ff < RefCw'(RefDepth)) rfill_next = rfill_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (is_ref && !ref_full_tab && in_last)
         end_mem[ctot_ff[ContigAw-1:0]] <= rfill_next;
   end

   logic clear_read;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctot_ff <= '0; rfill_ff <= '0; qfill_ff <= '0;
         rovf_ff <= 1'b0; qovf_ff <= 1'b0;
      end else begin
         if (is_ref) begin
            if (ref_full_tab) rovf_ff <= 1'b1;
            else begin
               if (rfill_ff >= RefCw'(RefDepth)) rovf_ff <= 1'b1;
               rfill_ff <= rfill_next;
               if (in_last) ctot_ff <= ctot_ff + 1'b1;
            end
         end
         if (is_read) begin
            if (qfill_ff < ReadCw'(MaxRead)) qfill_ff <= qfill_ff + 1'b1;
            else qovf_ff <= 1'b1;
         end
         if (in_take && in_type == ReqClear) begin
            ctot_ff <= '0; rfill_ff <= '0; rovf_ff <= 1'b0;
         end
         if (clear_read) begin
            qfill_ff <= '0; qovf_ff <= 1'b0;
         end
      end
   end

   // search datapath
   logic [ContigAw-1:0] k_ff;
   logic                kdone_ff;
   logic [RefCw-1:0]    cstart_ff, cend_ff, pos_ff;
   logic                rev_ff;
   logic [ReadCw-1:0]   i_ff;
   logic [3:0]          miss_ff;
   logic [3:0]          limit_ff;
   logic                bmap_ff, brev_ff;
   logic [3:0]          bcontig_ff, bmiss_ff;
   logic [13:0]         bpos_ff;
   logic [15:0]         ties_ff;
   logic [1:0]          stat_ff;
   logic [2:0]          qd_ff, rd_ff;
   logic                cmp_v_ff, qrev_ff;
   logic [RefCw-1:0]    endv;

   assign endv = end_mem[k_ff];
   assign clear_read = ctrl.finish;

   logic [RefCw-1:0] clen, len_ext;
   assign clen    = cend_ff - cstart_ff;
   assign len_ext = RefCw'(qfill_ff);

   assign stat.bad_status   = stat_ff != StatOk;
   assign stat.contigs_done = kdone_ff || ({1'b0, k_ff} >= ctot_ff);
   assign stat.contig_fits  = qfill_ff != '0 && len_ext <= clen;
   assign stat.windows_done = pos_ff > clen - len_ext;
   assign stat.last_base    = i_ff == qfill_ff - 1'b1;

   logic [ReadAw-1:0] qaddr;
   assign qaddr = rev_ff ? ReadAw'(qfill_ff - 1'b1 - i_ff) : i_ff[ReadAw-1:0];
   logic [RefCw-1:0] raddr;
   assign raddr = cstart_ff + pos_ff + RefCw'(i_ff);

   always_ff @(posedge clock) begin
      qd_ff    <= read_mem[qaddr];
      rd_ff    <= ref_mem[raddr[RefAw-1:0]];
      qrev_ff  <= rev_ff;
   end

   logic [2:0] qc;
   assign qc = (qrev_ff && qd_ff < 3'd4) ? 3'd3 - qd_ff : qd_ff;

   always_ff @(posedge clock) begin
      if (reset) cmp_v_ff <= 1'b0;
      else       cmp_v_ff <= ctrl.base_step;
   end

   logic [3:0] miss_sat;
   assign miss_sat = (miss_ff == 4'd15) ? miss_ff : miss_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         limit_ff <= (limit_raw > LimitCap) ? LimitCap : limit_raw;
         k_ff <= '0; kdone_ff <= 1'b0; cstart_ff <= '0;
         bmap_ff <= 1'b0; bcontig_ff <= '0; bpos_ff <= '0; brev_ff <= 1'b0;
         bmiss_ff <= '0; ties_ff <= '0;
         if (ctot_ff == '0)  stat_ff <= StatEmpty;
         else if (qovf_ff || (is_read && qfill_ff >= ReadCw'(MaxRead)))
            stat_ff <= StatReadOvf;
         else if (rovf_ff)   stat_ff <= StatRefOvf;
         else                stat_ff <= StatOk;
      end
      if (ctrl.load_contig) begin
         cend_ff <= (endv > RefCw'(RefDepth) || endv < cstart_ff) ? cstart_ff : endv;
         pos_ff <= '0; rev_ff <= 1'b0;
      end
      if (ctrl.win_start) begin
         i_ff <= '0; miss_ff <= '0;
      end
      if (ctrl.base_step) i_ff <= i_ff + 1'b1;
      if (cmp_v_ff && (qc >= 3'd4 || qc != rd_ff)) miss_ff <= miss_sat;
      if (ctrl.win_close && miss_ff <= limit_ff) begin
         if (!bmap_ff || miss_ff < bmiss_ff) begin
            bmap_ff <= 1'b1; bcontig_ff <= 4'(k_ff); bpos_ff <= 14'(pos_ff);
            brev_ff <= rev_ff; bmiss_ff <= miss_ff; ties_ff <= 16'd1;
         end else if (miss_ff == bmiss_ff && ties_ff != 16'hffff)
            ties_ff <= ties_ff + 1'b1;
      end
      if (ctrl.win_adv) begin
         rev_ff <= !rev_ff;
         if (rev_ff) pos_ff <= pos_ff + 1'b1;
      end
      if (ctrl.contig_adv) begin
         cstart_ff <= cend_ff;
         if (k_ff == ContigAw'(MaxContigs - 1)) kdone_ff <= 1'b1;
         else k_ff <= k_ff + 1'b1;
      end
   end

   assign res_mapped  = bmap_ff && stat_ff == StatOk;
   assign res_contig  = res_mapped ? bcontig_ff : '0;
   assign res_pos     = res_mapped ? bpos_ff : '0;
   assign res_rev     = res_mapped ? brev_ff : 1'b0;
   assign res_miss    = res_mapped ? bmiss_ff : '0;
   assign res_ties    = res_mapped ? ties_ff : '0;
   assign res_status  = stat_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/ungapped_hamming_read_aligner_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Ungapped Hamming read aligner.
// Request channel (req_valid/req_stall): one base item per cycle. Type 0
// appends a reference base (last closes a contig), type 1 buffers a read
// base, type 2 clears the reference store. Reference and non-final read
// items are taken every cycle while no search runs and no result waits.
// A read item with last set starts a search: req_stall rises while a
// controller walks every closed contig, window and strand, comparing one
// base per cycle through the registered store ports. Each window passes
// the window, base, drain and next states; a bad status skips the walk
// and goes straight to the result. The result item sits in an output
// register (rsp_valid/rsp_stall); a stalled result holds, and no new
// search starts until it is taken. Reset (synchronous, active high)
// empties the reference, the read buffer and the status flags and sets
// the mismatch limit to zero. The user must write the limit through
// csr_write_enable/csr_write_data while idle; the block does not enforce it.
module ungapped_hamming_read_aligner_top import uhra_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_req_type,
   input  wire logic [7:0]  req_base_char,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_mapped,
   output logic [3:0]       rsp_contig_number,
   output logic [13:0]      rsp_position,
   output logic             rsp_reverse_strand,
   output logic [3:0]       rsp_mismatch_count,
   output logic [15:0]      rsp_tie_count,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_write_enable,
   input  wire logic [3:0]  csr_write_data
);
   logic [3:0] limit_ff;
   always_ff @(posedge clock) begin
      if (reset) limit_ff <= '0;
      else if (csr_write_enable) limit_ff <= csr_write_data;
   end

   ctrl_type ctrl;
   stat_type stat;
   logic busy, done, take, go;

   // held off while searching or while a result waits
   assign req_stall = busy || rsp_valid;
   assign take = req_valid && !req_stall;
   assign go   = take && req_req_type == ReqRead && req_last;

   logic        m; logic [3:0] c, mc; logic [13:0] p; logic r;
   logic [15:0] t; logic [1:0] s;

   uhra_ctrl u_ctrl (
      .clock(clock), .reset(reset), .go(go), .stat(stat),
      .ctrl(ctrl), .busy(busy), .done(done)
   );

   uhra_datapath u_dp (
      .clock(clock), .reset(reset), .in_take(take), .in_type(req_req_type),
      .in_char(req_base_char), .in_last(req_last), .limit_raw(limit_ff),
      .ctrl(ctrl), .stat(stat), .res_mapped(m), .res_contig(c), .res_pos(p),
      .res_rev(r), .res_miss(mc), .res_ties(t), .res_status(s)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (done) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_mapped <= m; rsp_contig_number <= c; rsp_position <= p;
         rsp_reverse_strand <= r; rsp_mismatch_count <= mc;
         rsp_tie_count <= t; rsp_status <= s;
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/uhra_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "ungapped_hamming_read_aligner_top_assert.svh"
module uhra_checker import uhra_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_req_type,
   input wire logic        req_last,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_mapped,
   input wire logic [3:0]  rsp_mismatch_count,
   input wire logic [15:0] rsp_tie_count,
   input wire logic [1:0]  rsp_status
);
   `UHRA_ASSERT_NEXT(a_search_stalls, clock, reset,
      req_valid && !req_stall && req_req_type == ReqRead && req_last, req_stall,
      "search did not stall input")
   `UHRA_ASSERT_IMPLY(a_unmapped_zero, clock, reset, rsp_valid && !rsp_mapped,
      rsp_tie_count == 16'd0 && rsp_mismatch_count == 4'd0, "unmapped fields nonzero")
   `UHRA_ASSERT_IMPLY(a_mapped_ok, clock, reset, rsp_valid && rsp_mapped,
      rsp_status == StatOk && rsp_tie_count != 16'd0, "mapped with bad status")
   `UHRA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_tie_count), "stalled item changed")
endmodule

bind ungapped_hamming_read_aligner_top uhra_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_req_type(req_req_type), .req_last(req_last), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_mapped(rsp_mapped),
   .rsp_mismatch_count(rsp_mismatch_count), .rsp_tie_count(rsp_tie_count),
   .rsp_status(rsp_status)
);
`default_nettype wire

FILE: tb/sv/aligner_checker.sv
`timescale 1ns / 1ps
module aligner_checker import uhra_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_req_type,
   input  logic [7:0]  req_base_char,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_mapped,
   input  logic [3:0]  rsp_contig_number,
   input  logic [13:0] rsp_position,
   input  logic        rsp_reverse_strand,
   input  logic [3:0]  rsp_mismatch_count,
   input  logic [15:0] rsp_tie_count,
   input  logic [1:0]  rsp_status,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data,
   output int          fail_count,
   output int          pending
);
   typedef struct packed {
      logic        mapped;
      logic [3:0]  contig;
      logic [13:0] position;
      logic        reverse;
      logic [3:0]  misses;
      logic [15:0] ties;
      logic [1:0]  status;
   } hit_type;

   logic [2:0] ref_codes [RefDepth];
   int         contig_ends [MaxContigs];
   int         contigs;
   int         ref_len;
   logic [2:0] read_codes [MaxRead];
   int         read_len;
   bit         read_ovf;
   bit         ref_ovf;
   logic [3:0] limit;
   hit_type    expected_hits [$];

   initial fail_count = 0;
   initial pending = 0;

   function automatic logic [2:0] base_code(input logic [7:0] ch);
      logic [7:0] up;
      up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
      if (up == "A") return 3'd0;
      if (up == "C") return 3'd1;
      if (up == "G") return 3'd2;
      if (up == "T") return 3'd3;
      return CodeOther;
   endfunction

   function automatic hit_type best_hit();
      hit_type    h;
      int         lim, start, stop, clen, miss, best, ties;
      bit         found;
      logic [2:0] q;
      h = '0;
      found = 0;
      best = 0;
      ties = 0;
      lim = (limit > LimitCap) ? LimitCap : limit;
      if (contigs == 0) begin
         h.status = StatEmpty;
         return h;
      end
      if (read_ovf) begin
         h.status = StatReadOvf;
         return h;
      end
      if (ref_ovf) begin
         h.status = StatRefOvf;
         return h;
      end
      start = 0;
      for (int k = 0; k < contigs; k++) begin
         stop = contig_ends[k];
         if (stop > RefDepth || stop < start) stop = start;
         clen = stop - start;
         if (read_len > 0 && read_len <= clen) begin
            for (int pos = 0; pos <= clen - read_len; pos++) begin
               for (int s = 0; s < 2; s++) begin
                  miss = 0;
                  for (int i = 0; i < read_len; i++) begin
                     if (s == 0) q = read_codes[i];
                     else begin
                        q = read_codes[read_len - 1 - i];
                        if (q < 4) q = 3'd3 - q;
                     end
                     if (q >= 4 || q != ref_codes[start + pos + i]) miss++;
                  end
                  if (miss > lim) continue;
                  if (!found || miss < best) begin
                     found = 1;
                     best = miss;
                     ties = 1;
                     h.contig = k[3:0];
                     h.position = pos[13:0];
                     h.reverse = s[0];
                  end else if (miss == best && ties < 65535) begin
                     ties++;
                  end
               end
            end
         end
         start = stop;
      end
      if (found) begin
         h.mapped = 1'b1;
         h.misses = best[3:0];
         h.ties = ties[15:0];
      end else begin
         h = '0;
      end
      return h;
   endfunction

   task automatic take_item(input logic [1:0] kind, input logic [7:0] ch, input logic fin);
      logic [2:0] code;
      code = base_code(ch);
      case (kind)
         ReqRef: begin
            if (contigs >= MaxContigs) ref_ovf = 1;
            else begin
               if (ref_len < RefDepth) begin
                  ref_codes[ref_len] = code;
                  ref_len++;
               end else ref_ovf = 1;
               if (fin) begin
                  contig_ends[contigs] = ref_len;
                  contigs++;
               end
            end
         end
         ReqRead: begin
            if (read_len < MaxRead) begin
               read_codes[read_len] = code;
               read_len++;
            end else read_ovf = 1;
            if (fin) begin
               expected_hits.push_back(best_hit());
               read_len = 0;
               read_ovf = 0;
            end
         end
         ReqClear: begin
            contigs = 0;
            ref_len = 0;
            ref_ovf = 0;
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(input string name, input int exp_v, input int got_v);
      if (exp_v != got_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      hit_type h;
      if (reset) begin
         contigs = 0;
         ref_len = 0;
         read_len = 0;
         read_ovf = 0;
         ref_ovf = 0;
         limit = 4'd0;
         expected_hits.delete();
      end else begin
         if (csr_write_enable) limit = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual status %0d",
                        $time, rsp_status);
               fail_count++;
            end else begin
               h = expected_hits.pop_front();
               compare_field("mapped", h.mapped, rsp_mapped);
               compare_field("contig_number", h.contig, rsp_contig_number);
               compare_field("position", h.position, rsp_position);
               compare_field("reverse_strand", h.reverse, rsp_reverse_strand);
               compare_field("mismatch_count", h.misses, rsp_mismatch_count);
               compare_field("tie_count", h.ties, rsp_tie_count);
               compare_field("status", h.status, rsp_status);
            end
         end
         if (req_valid && !req_stall) take_item(req_req_type, req_base_char, req_last);
      end
      pending = expected_hits.size();
   end
endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import uhra_pkg::*;

   // request type 3 is ignored by the block: used as noise
   localparam logic [1:0] ReqIgnored = 2'd3;
   localparam int CycleLimit = 8_000_000;
   localparam int RandomItems = 1600;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_req_type = ReqRef;
   logic [7:0]  req_base_char = 8'h0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_mapped;
   logic [3:0]  rsp_contig_number;
   logic [13:0] rsp_position;
   logic        rsp_reverse_strand;
   logic [3:0]  rsp_mismatch_count;
   logic [15:0] rsp_tie_count;
   logic [1:0]  rsp_status;
   logic        csr_write_enable = 1'b0;
   logic [3:0]  csr_write_data = 4'd0;

   int  fail_count;
   int  pending;
   int  cycles = 0;
   int  items_sent = 0;
   bit  no_gaps = 0;    // back-to-back stretches on both channels
   int  rsp_hold = 0;

   // text of all closed contigs currently loaded, used to build reads that hit
   byte unsigned ref_text [$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ungapped_hamming_read_aligner_top i_dut (.*);

   aligner_checker i_checker (.*);

   // run guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int draw_wait();
      return no_gaps ? 0 : $urandom_range(0, 16);
   endfunction

   // result side: after each taken item, draw a wait and hold rsp_stall for it
   always @(posedge clock) begin : rsp_side
      int w;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         w = draw_wait();
         rsp_hold <= (w > 0) ? w - 1 : 0;
         rsp_stall <= (w > 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // one item: optional gap with valid low, then hold until taken
   task automatic send(input logic [1:0] kind, input byte unsigned ch, input logic fin);
      int gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_req_type <= kind;
      req_base_char <= ch;
      req_last <= fin;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // a dropped-read search may still be finishing; let the block finish it
      repeat (8) @(posedge clock);
   endtask

   task automatic set_limit(input logic [3:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_text(input logic [1:0] kind, input string s, input bit fin);
      for (int i = 0; i < s.len(); i++) begin
         send(kind, s[i], fin && (i == s.len() - 1));
         if (kind == ReqRef && fin) ref_text.push_back(s[i]);
      end
   endtask

   task automatic clear_ref();
      send(ReqClear, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      ref_text.delete();
   endtask

   function automatic byte unsigned any_base();
      int pick;
      string bases;
      bases = "ACGT";
      pick = $urandom_range(0, 19);
      if (pick < 16) return (pick % 2 != 0) ? (bases[pick / 4] | 8'h20) : bases[pick / 4];
      if (pick < 18) return (pick == 16) ? "N" : "n";
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic byte unsigned complement(input byte unsigned ch);
      byte unsigned low;
      low = ch | 8'h20;
      case (low)
         "a": return ch ^ ("A" ^ "T");
         "t": return ch ^ ("A" ^ "T");
         "c": return ch ^ ("C" ^ "G");
         "g": return ch ^ ("C" ^ "G");
         default: return ch;
      endcase
   endfunction

   task automatic load_contig(input int len, input bit close);
      byte unsigned ch;
      for (int i = 0; i < len; i++) begin
         ch = any_base();
         send(ReqRef, ch, close && (i == len - 1));
         if (close) ref_text.push_back(ch);
      end
   endtask

   // read copied from the loaded reference with some mutations, or random
   task automatic random_read(input int len);
      byte unsigned rd [$];
      byte unsigned ch;
      int start;
      if (ref_text.size() >= len && $urandom_range(0, 4) != 0) begin
         start = $urandom_range(0, ref_text.size() - len);
         for (int i = 0; i < len; i++) begin
            ch = ref_text[start + i];
            if ($urandom_range(0, 7) == 0) ch = any_base();
            if ($urandom_range(0, 1) == 0) ch = ch ^ ((ch | 8'h20) inside {"a", "c", "g", "t"}
                                                      ? 8'h20 : 8'h00);
            rd.push_back(ch);
         end
         if ($urandom_range(0, 2) == 0) begin
            rd.reverse();
            foreach (rd[i]) rd[i] = complement(rd[i]);
         end
      end else begin
         for (int i = 0; i < len; i++) rd.push_back(any_base());
      end
      foreach (rd[i]) begin
         if ($urandom_range(0, 30) == 0)
            send(ReqIgnored, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         send(ReqRead, rd[i], i == rd.size() - 1);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty reference, hits on both strands, limit extremes
      set_limit(4'd0);
      send_text(ReqRead, "A", 1);
      send_text(ReqRef, "ACGTACGT", 1);
      send_text(ReqRef, "ttgcaX", 1);
      send_text(ReqRead, "CGTA", 1);        // forward hit
      send_text(ReqRead, "TGCAA", 1);       // reverse complement of second contig
      send(ReqIgnored, 8'hFF, 1'b1);
      send_text(ReqRead, "ACGTACGTA", 1);   // longer than every contig
      set_limit(4'd15);                     // above the cap, acts as twelve
      send_text(ReqRead, "gN", 1);          // other bytes never match
      send(ReqRef, "C", 1'b0);              // open contig takes no part
      send_text(ReqRead, "C", 1);

      // read store overflow
      set_limit(4'd1);
      for (int i = 0; i < MaxRead; i++) send(ReqRead, "A", 1'b0);
      send(ReqRead, "C", 1'b1);
      send_text(ReqRead, "AC", 1);

      // contig table full
      no_gaps = 1;
      clear_ref();
      for (int i = 0; i < MaxContigs; i++) send(ReqRef, "A", 1'b1);
      send(ReqRef, "C", 1'b0);
      send_text(ReqRead, "A", 1);

      // reference store full: one long contig, hit at its very last position
      set_limit(4'd0);
      clear_ref();
      for (int i = 0; i < RefDepth - 1; i++) send(ReqRef, "A", 1'b0);
      send(ReqRef, "G", 1'b1);
      send_text(ReqRead, "G", 1);
      send(ReqRef, "A", 1'b1);
      send_text(ReqRead, "A", 1);
      clear_ref();
      no_gaps = 0;

      // random phases: limit, optional clear, a few contigs, then reads
      items_sent = 0;
      while (items_sent < RandomItems) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         set_limit(4'($urandom_range(0, 15)));
         if ($urandom_range(0, 2) == 0 || ref_text.size() > 80) clear_ref();
         repeat ($urandom_range(0, 3))
            load_contig($urandom_range(1, 24), $urandom_range(0, 9) != 0);
         repeat ($urandom_range(2, 6)) random_read($urandom_range(1, 12));
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/uhra_pkg.sv
hw/rtl/uhra_ctrl.sv
hw/rtl/uhra_datapath.sv
hw/rtl/ungapped_hamming_read_aligner_top.sv
hw/rtl/uhra_checker.sv
tb/sv/aligner_checker.sv
tb/sv/testbench.sv
